>>> rtl/slid_pkg.sv
// Shared types and constants for the sorted list insert/delete block.
`timescale 1ns / 1ps
package slid_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int VALUE_W         = 32;
    localparam int COUNT_OUT_W     = 5;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef struct packed {
        logic                       operation;
        logic signed [VALUE_W-1:0]  value;
    } t_item;

    typedef struct packed {
        logic [1:0]             status;
        logic [COUNT_OUT_W-1:0] entry_count;
    } t_result;

    // Broadcast from the control logic to every cell.
    typedef struct packed {
        logic                       do_insert;
        logic                       do_delete;
        logic signed [VALUE_W-1:0]  value;
    } t_cell_ctl;

    // Position flags a cell shows to its neighbors and to the control logic.
    typedef struct packed {
        logic ins_pos;   // at or after the insert point (or unoccupied)
        logic del_pos;   // occupied and holding a value >= the key
        logic eq;        // occupied and equal to the key
    } t_cell_flags;

endpackage

>>> rtl/sorted_list_insert_delete.sv
// Top level: sorted table of signed words built as a chain of shifting cells.
//
// Usage: present a command word on i_item and raise start. The word is taken
// at any rising edge where start is high and busy is low; busy never rises,
// so a new word may follow in every cycle. operation 0 inserts value before
// the first entry that is greater or equal, operation 1 deletes the first
// entry equal to value.
// Each word yields exactly one result word on o_result, marked by o_valid for
// one cycle, in the cycle after acceptance. status 0 means done, 1 means the
// insert was refused because the table is full, 2 means the delete found no
// match. entry_count is the number of entries held afterwards.
// Throughput is one word per cycle: every cell compares its entry with the
// broadcast key in parallel and the whole chain shifts at the same edge, so
// the critical path is one 32-bit compare plus the match OR over the chain.
// Reset (i_rst_n low, synchronous) empties the table and drops any pending
// result; the cell contents themselves are not cleared and are never read
// above the entry count. The receiver cannot stall: a result must be taken
// in its strobe cycle.
`timescale 1ns / 1ps
module sorted_list_insert_delete
    import slid_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_item   i_item,
    output logic    busy,
    output logic    o_valid,
    output t_result o_result
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_valid;
    logic          n_valid;
    t_result       r_result;
    t_result       n_result;

    logic          accept;
    logic          full;
    logic          found;
    t_cell_ctl     ctl;

    logic signed [VALUE_W-1:0] cell_data [TABLE_DEPTH];
    t_cell_flags               cell_flags [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]    eq_vec;

    // Every word is finished in the cycle it is taken.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign full  = (r_count == CW'(TABLE_DEPTH));
    assign found = |eq_vec;

    always_comb begin
        ctl.value     = i_item.value;
        ctl.do_insert = accept && (i_item.operation == OP_INSERT) && !full;
        ctl.do_delete = accept && (i_item.operation == OP_DELETE) && found;
    end

    // Cell chain: cell 0 is the head (smallest value).
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        logic                      left_ins_pos;
        logic signed [VALUE_W-1:0] left_data;
        logic signed [VALUE_W-1:0] right_data;

        if (g == 0) begin : g_head
            assign left_ins_pos = 1'b0;
            assign left_data    = cell_data[g];
        end else begin : g_body
            assign left_ins_pos = cell_flags[g-1].ins_pos;
            assign left_data    = cell_data[g-1];
        end

        // The tail pulls in its own value on delete; it falls out of range anyway.
        if (g == TABLE_DEPTH - 1) begin : g_tail
            assign right_data = cell_data[g];
        end else begin : g_mid
            assign right_data = cell_data[g+1];
        end

        slid_cell u_cell (
            .i_clk          (i_clk),
            .i_ctl          (ctl),
            .i_active       (CW'(g) < r_count),
            .i_left_ins_pos (left_ins_pos),
            .i_left_data    (left_data),
            .i_right_data   (right_data),
            .o_data         (cell_data[g]),
            .o_flags        (cell_flags[g])
        );

        assign eq_vec[g] = cell_flags[g].eq;
    end

    // Count update and result word.
    always_comb begin
        n_count = r_count;
        if (ctl.do_insert) begin
            n_count = r_count + CW'(1);
        end else if (ctl.do_delete) begin
            n_count = r_count - CW'(1);
        end
    end

    always_comb begin
        n_valid  = accept;
        n_result = r_result;
        if (accept) begin
            if (i_item.operation == OP_INSERT) begin
                n_result.status = full ? ST_FULL : ST_DONE;
            end else begin
                n_result.status = found ? ST_DONE : ST_NOT_FOUND;
            end
            n_result.entry_count = COUNT_OUT_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    // Payload holds without reset; only the strobe qualifies it.
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

>>> rtl/slid_cell.sv
// One entry of the sorted chain: holds a value and shifts toward either neighbor.
`timescale 1ns / 1ps
module slid_cell
    import slid_pkg::*;
(
    input  logic                       i_clk,
    input  t_cell_ctl                  i_ctl,
    input  logic                       i_active,
    input  logic                       i_left_ins_pos,
    input  logic signed [VALUE_W-1:0]  i_left_data,
    input  logic signed [VALUE_W-1:0]  i_right_data,
    output logic signed [VALUE_W-1:0]  o_data,
    output t_cell_flags                o_flags
);

    logic signed [VALUE_W-1:0] r_data;
    logic signed [VALUE_W-1:0] n_data;
    logic                      ge;

    assign ge = (r_data >= i_ctl.value);

    always_comb begin
        o_flags.ins_pos = ge || !i_active;
        o_flags.del_pos = ge && i_active;
        o_flags.eq      = i_active && (r_data == i_ctl.value);
    end

    // Sorted contents make the position flags monotone along the chain,
    // so the first cell of a run is found from the left neighbor alone.
    always_comb begin
        n_data = r_data;
        if (i_ctl.do_insert && o_flags.ins_pos) begin
            n_data = i_left_ins_pos ? i_left_data : i_ctl.value;
        end else if (i_ctl.do_delete && o_flags.del_pos) begin
            n_data = i_right_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

>>> tb/sorted_list_insert_delete_tb.sv
// Self-checking testbench for the sorted list insert/delete block.
`timescale 1ns / 1ps

import slid_pkg::*;

// Scoreboard: a shadow copy of the sorted table that predicts the result word
// for every accepted command word and checks results in arrival order.
class slid_scoreboard;
    logic signed [VALUE_W-1:0] shadow_tbl [TABLE_DEPTH_DEF];
    int unsigned               shadow_n;
    t_result                   pending_q [$];
    int unsigned               err_count;

    function new();
        shadow_n  = 0;
        err_count = 0;
    endfunction

    // Apply an accepted word to the shadow table and queue the expected result.
    function void note_word(t_item w);
        t_result                   exp_res;
        int unsigned               pos;
        int unsigned               hit;
        logic signed [VALUE_W-1:0] key;
        key = w.value;
        exp_res.status = ST_DONE;
        if (w.operation == OP_INSERT) begin
            if (shadow_n >= TABLE_DEPTH_DEF) begin
                exp_res.status = ST_FULL;
            end else begin
                pos = shadow_n;
                for (int i = shadow_n - 1; i >= 0; i--) begin
                    if (shadow_tbl[i] >= key) pos = i;
                end
                for (int i = shadow_n; i > pos; i--) shadow_tbl[i] = shadow_tbl[i-1];
                shadow_tbl[pos] = key;
                shadow_n++;
            end
        end else begin
            hit = shadow_n;
            for (int i = shadow_n - 1; i >= 0; i--) begin
                if (shadow_tbl[i] == key) hit = i;
            end
            if (hit == shadow_n) begin
                exp_res.status = ST_NOT_FOUND;
            end else begin
                for (int i = hit; i + 1 < shadow_n; i++) shadow_tbl[i] = shadow_tbl[i+1];
                shadow_n--;
            end
        end
        exp_res.entry_count = shadow_n[COUNT_OUT_W-1:0];
        pending_q.push_back(exp_res);
    endfunction

    task report_mismatch(string what);
        $display("MISMATCH @%0t: %s", $time, what);
        err_count++;
    endtask

    task check_result(t_result got);
        t_result exp_res;
        if (pending_q.size() == 0) begin
            report_mismatch($sformatf("result with nothing pending: status=%0d count=%0d",
                                      got.status, got.entry_count));
        end else begin
            exp_res = pending_q.pop_front();
            if (got.status !== exp_res.status)
                report_mismatch($sformatf("status got %0d want %0d",
                                          got.status, exp_res.status));
            if (got.entry_count !== exp_res.entry_count)
                report_mismatch($sformatf("entry_count got %0d want %0d",
                                          got.entry_count, exp_res.entry_count));
        end
    endtask
endclass

module sorted_list_insert_delete_tb;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam int RANDOM_WORDS = 800;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    t_item   i_item;
    logic    busy;
    logic    o_valid;
    t_result o_result;

    slid_scoreboard sb = new();

    // Count of words taken by the block; the driver polls it at falling edges.
    int unsigned words_taken = 0;
    // Insert idle gaps after words while set; clear it for back-to-back bursts.
    bit          gaps_on     = 1;

    sorted_list_insert_delete u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Monitor: check the result strobe before noting a new word, so that the
    // result of the word taken at the previous edge meets its own expectation.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) sb.check_result(o_result);
            if (start && !busy) begin
                sb.note_word(i_item);
                words_taken++;
            end
        end
    end

    // Present one command word and hold it until the block takes it; then, while
    // gaps_on is set, idle for a random gap. Call only at a falling edge.
    task automatic send_word(t_op op, logic signed [VALUE_W-1:0] v);
        int unsigned taken_before;
        int unsigned gap;
        t_item       w;
        t_item       noise;
        taken_before = words_taken;
        w.operation  = op;
        w.value      = v;
        start  <= 1'b1;
        i_item <= w;
        @(negedge i_clk);
        while (words_taken == taken_before) @(negedge i_clk);
        // Mostly short gaps, now and then a long one.
        gap = 0;
        if (gaps_on) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: gap = 0;
                6, 7, 8:          gap = $urandom_range(1, 3);
                default:          gap = $urandom_range(10, 40);
            endcase
        end
        if (gap > 0) begin
            // Drop start and scramble the payload while idle.
            noise.operation = 1'($urandom_range(0, 1));
            noise.value     = $urandom;
            start  <= 1'b0;
            i_item <= noise;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Fail the run if it hangs.
    initial begin
        #5_000_000;
        $display("sorted_list_insert_delete_tb NOT OK");
        $finish;
    end

    initial begin
        int unsigned               insert_pct;
        int unsigned               phase_left;
        int unsigned               drain_wait;
        t_op                       op;
        logic signed [VALUE_W-1:0] v;

        // Hold reset with all inputs at known values.
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_item  = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part: empty table, extremes, head insert and delete,
        // duplicates, a miss, then fill to full and try one more.
        send_word(OP_DELETE, 32'sd5);          // delete from an empty table
        send_word(OP_INSERT, VAL_MAX);
        send_word(OP_INSERT, VAL_MIN);         // new head
        send_word(OP_INSERT, 32'sd0);
        send_word(OP_INSERT, -32'sd1);
        send_word(OP_INSERT, 32'sd0);          // equal value goes before the old one
        send_word(OP_DELETE, VAL_MIN);         // remove the head
        send_word(OP_DELETE, 32'sd0);
        send_word(OP_DELETE, 32'sd12345);      // not present
        repeat (13) send_word(OP_INSERT, $urandom);
        send_word(OP_INSERT, -32'sd7);         // table is full: refused
        send_word(OP_DELETE, VAL_MAX);         // remove the tail

        // Random part in phases that lean toward filling, draining or neither,
        // so the table swings between empty and full many times.
        insert_pct = 50;
        phase_left = 0;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(15, 60);
                case ($urandom_range(0, 2))
                    0:       insert_pct = 85;
                    1:       insert_pct = 20;
                    default: insert_pct = 50;
                endcase
                // Some phases run with no idling at all.
                gaps_on = ($urandom_range(0, 3) != 0);
            end
            phase_left--;

            op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_DELETE;
            // Draw from a small pool to get duplicates and delete hits, from
            // the held entries, or from the full 32-bit range.
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    case ($urandom_range(0, 6))
                        0:       v = VAL_MIN;
                        1:       v = VAL_MAX;
                        default: v = $signed(32'($urandom_range(0, 4))) - 32'sd2;
                    endcase
                end
                3, 4, 5, 6: begin
                    if (sb.shadow_n > 0)
                        v = sb.shadow_tbl[$urandom_range(0, sb.shadow_n - 1)];
                    else
                        v = $urandom;
                end
                default: v = $urandom;
            endcase
            send_word(op, v);
        end

        // Drain: drop start and wait for every pending result, with a bound.
        start <= 1'b0;
        drain_wait = 0;
        while (sb.pending_q.size() != 0 && drain_wait < 1000) begin
            @(negedge i_clk);
            drain_wait++;
        end
        repeat (5) @(negedge i_clk);
        while (sb.pending_q.size() != 0) begin
            void'(sb.pending_q.pop_front());
            sb.report_mismatch("expected result never arrived");
        end

        if (sb.err_count == 0)
            $display("sorted_list_insert_delete_tb OK");
        else
            $display("sorted_list_insert_delete_tb NOT OK");
        $finish;
    end

endmodule

>>> sim.f
rtl/slid_pkg.sv
rtl/slid_cell.sv
rtl/sorted_list_insert_delete.sv
tb/sorted_list_insert_delete_tb.sv
